[rtl/pidrc_pkg.sv]
// ----------------------------------------------------------------------------
// PID regulator package
// Widths, fixed-point constants and register indexes shared by the regulator.
// ----------------------------------------------------------------------------
package pidrc_pkg;

  localparam int SampleW   = 16;
  localparam int ErrorW    = SampleW + 1;
  localparam int GainW     = 24;
  localparam int LimitW    = 15;
  localparam int QFrac     = 12;
  localparam int IntegralW = LimitW + QFrac + 1;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = GainW;

  localparam logic [CfgIndexW-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_OUTPUT_LIMIT   = 3'd4;

endpackage

[rtl/pid_regulator_clamped.sv]
// ----------------------------------------------------------------------------
// PID regulator with integral clamp
// Positional fixed-point PID controller with a clamped integral and a
// saturated drive output.
// ----------------------------------------------------------------------------
// The regulator takes one word per clock cycle while the output side is not
// stalled; each word passes the input register, then the result register.
// The cycle is set by the integral loop: the error multiply by gain_i, the add
// to the stored integral and the clamp all complete between the input register
// and the result register, alongside the proportional and derivative
// multiplies. Gains are unsigned Q12.12, the integral keeps 12 fraction bits,
// and the drive is the floor of the Q12 sum saturated to the output limit.
// The user writes configuration only while no word is in flight; unchecked.
module pid_regulator_clamped
  import pidrc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SampleW-1:0]   target,
  input  logic signed [SampleW-1:0]   measured,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SampleW-1:0]   drive,
  input  logic                        cfg_we,
  input  logic        [CfgIndexW-1:0] cfg_index,
  input  logic        [CfgDataW-1:0]  cfg_data
);

  localparam int PTermW = ErrorW + GainW;
  localparam int DErrW  = ErrorW + 1;
  localparam int DTermW = DErrW + GainW;
  localparam int NewIW  = DTermW;
  localparam int SumW   = DTermW + 2;
  localparam int FloorW = SumW - QFrac;

  logic [GainW-1:0]  gain_p;
  logic [GainW-1:0]  gain_i;
  logic [GainW-1:0]  gain_d;
  logic [LimitW-1:0] integral_limit;
  logic [LimitW-1:0] output_limit;

  logic                      s0_valid;
  logic signed [SampleW-1:0] target_q;
  logic signed [SampleW-1:0] measured_q;

  logic signed [IntegralW-1:0] integral_acc;
  logic signed [ErrorW-1:0]    previous_error;

  logic                        out_en;
  logic signed [ErrorW-1:0]    err;
  logic signed [DErrW-1:0]     derr;
  logic signed [PTermW-1:0]    p_term;
  logic signed [PTermW-1:0]    i_prod;
  logic signed [DTermW-1:0]    d_term;
  logic signed [NewIW-1:0]     new_i;
  logic signed [NewIW-1:0]     lim_pos;
  logic signed [IntegralW-1:0] integral_next;
  logic signed [SumW-1:0]      sum;
  logic signed [FloorW-1:0]    sum_floor;
  logic signed [FloorW-1:0]    olim;
  logic signed [SampleW-1:0]   drive_next;

  assign out_en   = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:         gain_p         <= cfg_data;
        REG_GAIN_I:         gain_i         <= cfg_data;
        REG_GAIN_D:         gain_d         <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LimitW-1:0];
        REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err     = $signed({target_q[SampleW-1], target_q})
            - $signed({measured_q[SampleW-1], measured_q});
    derr    = $signed({err[ErrorW-1], err})
            - $signed({previous_error[ErrorW-1], previous_error});
    p_term  = PTermW'(err) * PTermW'($signed({1'b0, gain_p}));
    i_prod  = PTermW'(err) * PTermW'($signed({1'b0, gain_i}));
    d_term  = DTermW'(derr) * DTermW'($signed({1'b0, gain_d}));
    new_i   = NewIW'(integral_acc) + NewIW'(i_prod);
    lim_pos = NewIW'($signed({1'b0, integral_limit, {QFrac{1'b0}}}));

    if (gain_i == '0) begin
      integral_next = '0;
    end else if (new_i > lim_pos) begin
      integral_next = IntegralW'(lim_pos);
    end else if (new_i < -lim_pos) begin
      integral_next = IntegralW'(-lim_pos);
    end else begin
      integral_next = new_i[IntegralW-1:0];
    end

    sum       = SumW'(p_term) + SumW'(integral_next) + SumW'(d_term);
    sum_floor = sum[SumW-1:QFrac];
    olim      = $signed({{(FloorW-LimitW){1'b0}}, output_limit});

    if (sum_floor >= olim) begin
      drive_next = $signed({1'b0, output_limit});
    end else if (sum_floor < -olim) begin
      drive_next = -$signed({1'b0, output_limit});
    end else begin
      drive_next = sum_floor[SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      out_valid      <= 1'b0;
      integral_acc   <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (out_en) begin
        out_valid      <= 1'b1;
        integral_acc   <= integral_next;
        previous_error <= err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      target_q   <= target;
      measured_q <= measured;
    end
    if (out_en) begin
      drive <= drive_next;
    end
  end

  // The integral is cleared whenever a word passes with zero integral gain.
  a_integral_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_en && gain_i == '0) |=> (integral_acc == '0))
    else $error("integral not cleared with zero integral gain");

  // A held result always respects the output limit.
  a_drive_limited: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= $signed({1'b0, output_limit})
                   && drive >= -$signed({1'b0, output_limit})))
    else $error("drive outside output limit");

  // The stored error follows the word that just completed.
  a_prev_error: assert property (@(posedge clk) disable iff (rst)
    out_en |=> (previous_error == $past(err)))
    else $error("previous error not updated");

  // A new result only appears when a word was waiting in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s0_valid))
    else $error("result without a pending word");

endmodule
